/* rtl/core/ptts_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the periodic task tick scheduler.
// No dependencies; imported by the controller, datapath and top level.
package ptts_pkg;

    localparam int NUM_TASKS_DEF = 8;
    localparam int ACT_W         = 3;
    localparam int MASK_W        = 8;
    localparam int PERIOD_W      = 16;
    localparam int DELAY_W       = 8;

    typedef logic [ACT_W-1:0]    t_act;
    typedef logic [MASK_W-1:0]   t_mask;
    typedef logic [PERIOD_W-1:0] t_count;

    localparam t_act ACT_TICK    = 3'd0;
    localparam t_act ACT_CREATE  = 3'd1;
    localparam t_act ACT_SUSPEND = 3'd2;
    localparam t_act ACT_RESUME  = 3'd3;
    localparam t_act ACT_DELETE  = 3'd4;

    typedef struct packed {
        logic tick_start;
        logic op_en;
        logic rd_en;
    } t_dp_cmd;

endpackage

/* rtl/core/ptts_ctrl.sv */
`timescale 1ns / 1ps
// Controller for the periodic task tick scheduler: handshake and slot walk.
// Depends on ptts_pkg.
module ptts_ctrl
    import ptts_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF,
    parameter int IDXW      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  t_act            i_action,
    output logic            busy,
    output logic            o_valid,
    output t_dp_cmd         o_cmd,
    output logic [IDXW-1:0] o_rd_idx
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_TASKS - 1);

    logic [1:0]      r_state, n_state;
    logic [IDXW-1:0] r_idx, n_idx;
    logic            accept;

    assign accept = start && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_action == ACT_TICK)) begin
                    n_state = ST_WALK;
                    n_idx   = '0;
                end
            end
            ST_WALK: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign busy             = (r_state != ST_IDLE);
    assign o_valid          = (r_state == ST_DONE);
    assign o_cmd.tick_start = accept && (i_action == ACT_TICK);
    assign o_cmd.op_en      = accept && (i_action != ACT_TICK);
    assign o_cmd.rd_en      = (r_state == ST_WALK);
    assign o_rd_idx         = r_idx;

endmodule

/* rtl/core/ptts_dp.sv */
`timescale 1ns / 1ps
// Datapath for the periodic task tick scheduler: slot flags, period and
// countdown memories, reload/decrement stage and fired mask. Depends on ptts_pkg.
module ptts_dp
    import ptts_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF,
    parameter int IDXW      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [IDXW-1:0]     i_rd_idx,
    input  t_act                i_action,
    input  logic [2:0]          i_task_id,
    input  t_count              i_period,
    input  logic [DELAY_W-1:0]  i_first_delay,
    output t_mask               o_mask
);

    logic [NUM_TASKS-1:0] r_present, n_present;
    logic [NUM_TASKS-1:0] r_ready, n_ready;
    t_count               r_per_mem [NUM_TASKS];
    t_count               r_cnt_mem [NUM_TASKS];
    t_count               r_rd_per, r_rd_cnt;
    logic                 r_stg_vld;
    logic [IDXW-1:0]      r_stg_idx;
    t_mask                r_mask, n_mask;

    logic            id_ok;
    logic [IDXW-1:0] id_idx;
    logic            stg_act, stg_fire;
    t_count          stg_cnt;
    logic            wr_en, wr_per;
    logic [IDXW-1:0] wr_addr;
    t_count          wr_cnt;

    assign id_ok  = (32'(i_task_id) < NUM_TASKS);
    assign id_idx = IDXW'(i_task_id);

    assign stg_act  = r_stg_vld && r_present[r_stg_idx] && r_ready[r_stg_idx];
    assign stg_fire = stg_act && (r_rd_cnt == '0);
    assign stg_cnt  = stg_fire ? (r_rd_per - 1'b1) : (r_rd_cnt - 1'b1);

    always_comb begin
        n_present = r_present;
        n_ready   = r_ready;
        wr_en     = 1'b0;
        wr_per    = 1'b0;
        wr_addr   = r_stg_idx;
        wr_cnt    = stg_cnt;
        if (i_cmd.op_en && id_ok) begin
            case (i_action)
                ACT_CREATE: begin
                    n_present[id_idx] = 1'b1;
                    n_ready[id_idx]   = 1'b1;
                    wr_en             = 1'b1;
                    wr_per            = 1'b1;
                    wr_addr           = id_idx;
                    wr_cnt            = PERIOD_W'(i_first_delay);
                end
                ACT_SUSPEND: begin
                    n_ready[id_idx] = 1'b0;
                end
                ACT_RESUME: begin
                    n_ready[id_idx] = 1'b1;
                end
                ACT_DELETE: begin
                    n_present[id_idx] = 1'b0;
                end
                default: begin
                end
            endcase
        end else if (stg_act) begin
            wr_en = 1'b1;
        end
    end

    always_comb begin
        n_mask = r_mask;
        if (i_cmd.tick_start) begin
            n_mask = '0;
        end else if (stg_fire) begin
            n_mask = r_mask | t_mask'(8'd1 << r_stg_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_ready   <= '0;
            r_stg_vld <= 1'b0;
        end else begin
            r_present <= n_present;
            r_ready   <= n_ready;
            r_stg_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stg_idx <= i_rd_idx;
        r_mask    <= n_mask;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cnt_mem[wr_addr] <= wr_cnt;
        end
        if (wr_per) begin
            r_per_mem[wr_addr] <= i_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_per <= r_per_mem[i_rd_idx];
            r_rd_cnt <= r_cnt_mem[i_rd_idx];
        end
    end

    assign o_mask = r_mask;

endmodule

/* rtl/core/periodic_task_tick_scheduler.sv */
`timescale 1ns / 1ps
// Top level of the periodic task tick scheduler: controller plus datapath.
// Depends on ptts_pkg, ptts_ctrl and ptts_dp.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | start, busy        | i_action, i_task_id, i_period, i_first_delay
//  out     | o_valid (strobe)   | o_fired_mask
//
// Create, suspend, resume, delete and unknown actions finish in the accept cycle;
// busy stays low and the next item may follow on the next cycle.
// A tick walks the slots one per cycle through the registered-read period and
// countdown memories; busy covers the walk, drain and done states, o_valid the done state.
// Reset is synchronous and clears the present and ready flags at once.
// The receiver cannot stall; o_valid is high for exactly one cycle per tick.
module periodic_task_tick_scheduler
    import ptts_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_act               i_action,
    input  logic [2:0]         i_task_id,
    input  t_count             i_period,
    input  logic [DELAY_W-1:0] i_first_delay,
    output logic               o_valid,
    output t_mask              o_fired_mask
);

    localparam int IDXW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    t_dp_cmd         cmd;
    logic [IDXW-1:0] rd_idx;

    ptts_ctrl #(
        .NUM_TASKS (NUM_TASKS),
        .IDXW      (IDXW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_cmd    (cmd),
        .o_rd_idx (rd_idx)
    );

    ptts_dp #(
        .NUM_TASKS (NUM_TASKS),
        .IDXW      (IDXW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_rd_idx      (rd_idx),
        .i_action      (i_action),
        .i_task_id     (i_task_id),
        .i_period      (i_period),
        .i_first_delay (i_first_delay),
        .o_mask        (o_fired_mask)
    );

    a_tick_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == ACT_TICK)) |=> busy)
        else $error("tick accepted without entering the slot walk");

    a_op_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action != ACT_TICK)) |=> (!busy && !o_valid))
        else $error("non-tick item started a walk or produced a result");

    a_result_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!busy && !o_valid))
        else $error("result strobe not followed by idle");

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (busy && $past(busy)))
        else $error("result strobe outside a tick walk");

endmodule
